// File: src/lehmer128_rng_with_hash_reseed_defines.svh
// Assertion macros shared by the RTL files.
// They sample on clock and stay quiet while reset is high.
`ifndef LEHMER128_RNG_WITH_HASH_RESEED_DEFINES_SVH
`define LEHMER128_RNG_WITH_HASH_RESEED_DEFINES_SVH

// Same-cycle implication.
`define LRNG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication.
`define LRNG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: src/lrng_pkg.sv
`default_nettype none

package lrng_pkg;

   localparam logic [63:0] MIX_C1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_C2   = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] LCG_MULT = 64'd15750249268501108917;
   localparam int unsigned MIX_SHIFT = 33;

   localparam logic CMD_RESEED   = 1'b0;
   localparam logic CMD_GENERATE = 1'b1;

   // Partial products of a 128 x 64 product mod 2^128, low weights first.
   // The first three alone give the product mod 2^64.
   // Entry 0 sits in the lowest slice of each constant.
   localparam logic [6:0][1:0] STEP_I = {2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
   localparam logic [6:0]      STEP_J = 7'b1010100;
   localparam logic [2:0] STEP_LAST_WIDE   = 3'd6;
   localparam logic [2:0] STEP_LAST_NARROW = 3'd2;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL1 = 5'b00010,
      ST_MUL2 = 5'b00100,
      ST_STEP = 5'b01000,
      ST_EMIT = 5'b10000
   } lrng_state_type;

   typedef struct packed {
      logic         start;
      logic         wide;
      logic [127:0] x;
      logic [63:0]  y;
   } lrng_mul_req_type;

   function automatic logic [63:0] xorshift(input logic [63:0] k);
      return k ^ (k >> MIX_SHIFT);
   endfunction

endpackage

`default_nettype wire

// File: src/lrng_mul.sv
`default_nettype none

module lrng_mul (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= a * b;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// File: src/lrng_mulacc.sv
`default_nettype none

`include "lehmer128_rng_with_hash_reseed_defines.svh"

module lrng_mulacc (
   input  logic                     clock,
   input  logic                     reset,
   input  lrng_pkg::lrng_mul_req_type req,
   output logic                     done,
   output logic [127:0]             acc
);
   import lrng_pkg::*;

   logic [127:0] x_ff;
   logic [63:0]  y_ff;
   logic         wide_ff;
   logic [2:0]   step_ff;
   logic         run_ff;
   logic         pp_vld_ff;
   logic         last_ff;
   logic [1:0]   sh_ff;
   logic [127:0] acc_ff;
   logic         done_ff;

   logic [31:0]  dig_a;
   logic [31:0]  dig_b;
   logic [63:0]  pp;
   logic         is_last;
   logic [127:0] pp_shifted;

   assign dig_a   = x_ff[{STEP_I[step_ff], 5'b00000} +: 32];
   assign dig_b   = y_ff[{STEP_J[step_ff], 5'b00000} +: 32];
   assign is_last = step_ff == (wide_ff ? STEP_LAST_WIDE : STEP_LAST_NARROW);

   lrng_mul u_mul (
      .clock (clock),
      .en    (run_ff),
      .a     (dig_a),
      .b     (dig_b),
      .p     (pp)
   );

   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_shifted = {64'b0, pp};
         2'd1:    pp_shifted = {32'b0, pp, 32'b0};
         2'd2:    pp_shifted = {pp, 64'b0};
         default: pp_shifted = {pp[31:0], 96'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         pp_vld_ff <= run_ff;
         done_ff   <= pp_vld_ff && last_ff;
         if (req.start) begin
            run_ff <= 1'b1;
         end else if (run_ff && is_last) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= STEP_I[step_ff] + {1'b0, STEP_J[step_ff]};
      last_ff <= is_last;
      if (req.start) begin
         x_ff    <= req.x;
         y_ff    <= req.y;
         wide_ff <= req.wide;
         step_ff <= 3'd0;
         acc_ff  <= '0;
      end else begin
         if (run_ff) begin
            step_ff <= step_ff + 3'd1;
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

   `LRNG_ASSERT_IMP(a_start_when_free, req.start, !run_ff && !pp_vld_ff)
   `LRNG_ASSERT_IMP(a_done_drained, done_ff, !run_ff && !pp_vld_ff)

endmodule

`default_nettype wire

// File: src/lehmer128_rng_with_hash_reseed.sv
// 128-bit multiplicative congruential generator with hash reseeding. A generate
// item (command 1) multiplies the 128-bit state by a fixed odd 64-bit constant
// and returns the high 64 bits of the new state; the first generate after reset
// reseeds first from its own entropy fields. A reseed item (command 0) folds the
// fmix64 hash of the timestamp entropy, then that of the process entropy, into
// the low state word and returns nothing. All multiplies run on one 32x32
// multiplier stepped through partial products. One item is in flight at a
// time; req_ready is high only while the block is idle, and a finished result
// waits in an output register until taken.
`default_nettype none

`include "lehmer128_rng_with_hash_reseed_defines.svh"

module lehmer128_rng_with_hash_reseed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [63:0] req_timestamp_entropy,
   input  logic [31:0] req_process_entropy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_random_value
);
   import lrng_pkg::*;

   lrng_state_type   state_ff, state_in;
   logic             cmd_ff, cmd_in;
   logic [31:0]      proc_ff, proc_in;
   logic [63:0]      k_ff, k_in;
   logic             pass_ff, pass_in;
   logic             issued_ff, issued_in;
   logic [63:0]      pool_lo_ff, pool_lo_in;
   logic [63:0]      pool_hi_ff, pool_hi_in;
   logic             seeded_ff, seeded_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;

   lrng_mul_req_type mul_req;
   logic             mul_done;
   logic [127:0]     mul_acc;
   logic             emit_load;

   lrng_mulacc u_mulacc (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .acc   (mul_acc)
   );

   always_comb begin
      mul_req.start = !issued_ff &&
                      (state_ff == ST_MUL1 || state_ff == ST_MUL2 || state_ff == ST_STEP);
      mul_req.wide  = state_ff == ST_STEP;
      unique case (state_ff)
         ST_MUL1: begin
            mul_req.x = {64'b0, xorshift(k_ff)};
            mul_req.y = MIX_C1;
         end
         ST_MUL2: begin
            mul_req.x = {64'b0, xorshift(k_ff)};
            mul_req.y = MIX_C2;
         end
         ST_STEP: begin
            mul_req.x = {pool_hi_ff, pool_lo_ff};
            mul_req.y = LCG_MULT;
         end
         default: begin
            mul_req.x = '0;
            mul_req.y = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      proc_in      = proc_ff;
      k_in         = k_ff;
      pass_in      = pass_ff;
      pool_lo_in   = pool_lo_ff;
      pool_hi_in   = pool_hi_ff;
      seeded_in    = seeded_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      priority if (mul_req.start) begin
         issued_in = 1'b1;
      end else if (mul_done) begin
         issued_in = 1'b0;
      end else begin
         issued_in = issued_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_command;
               proc_in = req_process_entropy;
               k_in    = req_timestamp_entropy;
               pass_in = 1'b0;
               state_in = (req_command == CMD_GENERATE && seeded_ff) ? ST_STEP : ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (mul_done) begin
               k_in     = mul_acc[63:0];
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_done) begin
               pool_lo_in = pool_lo_ff ^ xorshift(mul_acc[63:0]);
               priority if (!pass_ff) begin
                  // second hash: process entropy
                  pass_in  = 1'b1;
                  k_in     = {32'b0, proc_ff};
                  state_in = ST_MUL1;
               end else if (cmd_ff == CMD_GENERATE) begin
                  seeded_in = 1'b1;
                  state_in  = ST_STEP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STEP: begin
            if (mul_done) begin
               pool_lo_in = mul_acc[63:0];
               pool_hi_in = mul_acc[127:64];
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = pool_hi_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         pool_lo_ff   <= '0;
         pool_hi_ff   <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         pool_lo_ff   <= pool_lo_in;
         pool_hi_ff   <= pool_hi_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      proc_ff     <= proc_in;
      k_ff        <= k_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;
   assign emit_load        = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   `LRNG_ASSERT_IMP(a_step_seeded, state_ff == ST_STEP, seeded_ff)
   `LRNG_ASSERT_NEXT(a_emit_loads, emit_load, rsp_valid_ff && (rsp_data_ff == pool_hi_ff))
   `LRNG_ASSERT_NEXT(a_emit_idles, emit_load, state_ff == ST_IDLE)

endmodule

`default_nettype wire

// File: tb/sv/lehmer128_rng_with_hash_reseed_test.sv
`timescale 1ns / 100ps

module lehmer128_rng_with_hash_reseed_test;
   import lrng_pkg::*;

   localparam logic [63:0] HASH_MUL_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] HASH_MUL_B = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] POOL_MULT  = 64'd15750249268501108917;
   localparam int unsigned HASH_SHIFT = 33;
   localparam int          HOLD_CYCLES = 300;
   localparam int          DRAIN_CYCLES = 80;
   localparam int          RANDOM_ITEMS = 470;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_command = CMD_RESEED;
   logic [63:0] req_timestamp_entropy = '0;
   logic [31:0] req_process_entropy = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_random_value;

   // predicted generator state
   logic [127:0] rng_pool = '0;
   logic         rng_seeded = 1'b0;
   logic [63:0]  expected_words[$];

   int fail_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_armed = 1'b0;
   logic hold_done = 1'b0;

   lehmer128_rng_with_hash_reseed uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_timestamp_entropy(req_timestamp_entropy),
      .req_process_entropy(req_process_entropy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_random_value(rsp_random_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] hash_mix64(input logic [63:0] k);
      logic [63:0] h;
      h = k ^ (k >> HASH_SHIFT);
      h = h * HASH_MUL_A;
      h = h ^ (h >> HASH_SHIFT);
      h = h * HASH_MUL_B;
      h = h ^ (h >> HASH_SHIFT);
      return h;
   endfunction

   function automatic void blend_entropy(input logic [63:0] stamp, input logic [31:0] proc);
      rng_pool[63:0] = rng_pool[63:0] ^ hash_mix64(stamp);
      rng_pool[63:0] = rng_pool[63:0] ^ hash_mix64({32'd0, proc});
   endfunction

   // Update the predicted state for one accepted item; queue the word a generate returns.
   function automatic void predict_item(input logic cmd, input logic [63:0] stamp,
                                        input logic [31:0] proc);
      if (cmd == CMD_RESEED) begin
         blend_entropy(stamp, proc);
      end else begin
         if (!rng_seeded) begin
            blend_entropy(stamp, proc);
            rng_seeded = 1'b1;
         end
         rng_pool = rng_pool * {64'd0, POOL_MULT};
         expected_words.push_back(rng_pool[127:64]);
      end
   endfunction

   function automatic logic [63:0] random_entropy64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'h8000000000000000;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Result side: stall at random, or hold off for a long stretch when armed.
   initial begin
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            rsp_ready <= 1'b0;
            held++;
            if (held >= HOLD_CYCLES) hold_done <= 1'b1;
         end else begin
            held = 0;
            if (!hold_armed) hold_done <= 1'b0;
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $error("random_value: no result pending, got %h", rsp_random_value);
            fail_count++;
         end else begin
            logic [63:0] want;
            want = expected_words.pop_front();
            if (rsp_random_value !== want) begin
               $error("random_value: expected %h, actual %h", want, rsp_random_value);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(input logic cmd, input logic [63:0] stamp, input logic [31:0] proc);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_timestamp_entropy <= stamp;
      req_process_entropy <= proc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cmd, stamp, proc);
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      // reseeds before any generate leave the block unseeded
      send_item(CMD_RESEED, 64'd0, 32'd0);
      send_item(CMD_RESEED, '1, '1);
      // first generate reseeds from its own entropy
      send_item(CMD_GENERATE, 64'h0123456789abcdef, 32'h89abcdef);
      send_item(CMD_GENERATE, '1, '1);
      send_item(CMD_GENERATE, 64'd0, 32'd0);
      send_item(CMD_RESEED, '1, 32'd0);
      send_item(CMD_RESEED, 64'd0, '1);
      send_item(CMD_GENERATE, 64'd0, 32'd0);
      send_item(CMD_RESEED, 64'h8000000000000000, 32'h80000000);
      send_item(CMD_RESEED, 64'd1, 32'd1);
      send_item(CMD_GENERATE, 64'd1, 32'd1);
      send_item(CMD_GENERATE, 64'h8000000000000000, 32'h80000000);
      send_item(CMD_RESEED, 64'haaaaaaaaaaaaaaaa, 32'h55555555);
      send_item(CMD_RESEED, 64'h5555555555555555, 32'haaaaaaaa);
      send_item(CMD_GENERATE, 64'haaaaaaaaaaaaaaaa, 32'h55555555);
      wait_drained();
   endtask

   task automatic run_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         send_item(($urandom_range(0, 99) < 65) ? CMD_GENERATE : CMD_RESEED,
                   random_entropy64(), $urandom);
      end
      wait_drained();
   endtask

   task automatic test_no_idle();
      run_random(RANDOM_ITEMS, 0, 0);
   endtask

   task automatic test_sender_idle();
      run_random(RANDOM_ITEMS, 80, 0);
   endtask

   task automatic test_receiver_stall();
      run_random(RANDOM_ITEMS, 0, 80);
   endtask

   task automatic test_both_idle();
      run_random(RANDOM_ITEMS, 17, 17);
   endtask

   // Hold the result side off while items keep coming, so input stalls.
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_armed = 1'b1;
      for (int n = 0; n < 12; n++) begin
         send_item((n % 3 == 2) ? CMD_RESEED : CMD_GENERATE, random_entropy64(), $urandom);
      end
      wait (hold_done);
      hold_armed = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_no_idle();
      test_sender_idle();
      test_output_backpressure();
      test_receiver_stall();
      test_both_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("random_value: %0d results never arrived", expected_words.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
